/* design/sorted_table_binary_search_core_assert.svh */
// ----------------------------------------------------------------------------
// Sorted table assertion macros
// Assertion macros used by the sorted table sequencer (stbs_ctrl).
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STBS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table package
// Field widths, action codes and the command word sent to the cell row.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int ACT_W   = 2;
  localparam int KEY_W   = 32;
  localparam int CMP_W   = 4;
  localparam int ENTRY_W = 11;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  typedef struct packed {
    logic load_flags;
    logic do_insert;
    logic do_delete;
  } stbs_cmd_t;

endpackage

/* design/stbs_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one action and key per item.
// ----------------------------------------------------------------------------
interface stbs_req_if import stbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

/* design/stbs_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface stbs_rsp_if import stbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               success;
  logic               table_full;
  logic [CMP_W-1:0]   comparisons;
  logic [ENTRY_W-1:0] entry_count;

  modport source (output valid, output success, output table_full,
                  output comparisons, output entry_count, input ready);
  modport sink (input valid, input success, input table_full,
                input comparisons, input entry_count, output ready);
endinterface

/* design/stbs_cell.sv */
// ----------------------------------------------------------------------------
// Table cell
// Holds one key, registers its compare flags and shifts with its neighbors.
// ----------------------------------------------------------------------------
module stbs_cell import stbs_pkg::*; (
  input  logic                    clk,
  input  stbs_cmd_t               cmd,
  input  logic                    at_pos,
  input  logic                    above_pos,
  input  logic signed [KEY_W-1:0] key_in,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key,
  output logic                    lt,
  output logic                    eq
);

  always_ff @(posedge clk) begin
    if (cmd.load_flags) begin
      lt <= key < key_in;
      eq <= key == key_in;
    end
    if (cmd.do_insert) begin
      if (at_pos) begin
        key <= key_in;
      end else if (above_pos) begin
        key <= left_key;
      end
    end else if (cmd.do_delete && (at_pos || above_pos)) begin
      key <= right_key;
    end
  end

endmodule

/* design/stbs_cell_row.sv */
// ----------------------------------------------------------------------------
// Cell row
// Chain of table cells; each cell takes its neighbor's key on a shift.
// ----------------------------------------------------------------------------
module stbs_cell_row import stbs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  stbs_cmd_t               cmd,
  input  logic [IW-1:0]           pos,
  input  logic signed [KEY_W-1:0] key_in,
  output logic [DEPTH-1:0]        lt_flags,
  output logic [DEPTH-1:0]        eq_flags
);

  logic signed [KEY_W-1:0] keys [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = key_in;
    end else begin : g_mid
      assign left_key = keys[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    stbs_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .at_pos    (pos == IW'(i)),
      .above_pos (pos < IW'(i)),
      .key_in    (key_in),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (keys[i]),
      .lt        (lt_flags[i]),
      .eq        (eq_flags[i])
    );
  end

endmodule

/* design/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// Search sequencer
// Runs the binary search over the cell flags and issues the table update.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_assert.svh"

module stbs_ctrl import stbs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  stbs_req_if.sink                req,
  stbs_rsp_if.source              rsp,
  input  logic [DEPTH-1:0]        lt_flags,
  input  logic [DEPTH-1:0]        eq_flags,
  output stbs_cmd_t               cmd,
  output logic [IW-1:0]           pos,
  output logic signed [KEY_W-1:0] key
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [1:0] {IDLE, COMPARE, PROBE, FINISH} state_t;

  state_t             state;
  logic [ACT_W-1:0]   act;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      mid;
  logic [CMP_W-1:0]   probes;
  logic               ok;
  logic               full;
  logic               fire;
  logic               probe_lt;
  logic               probe_eq;
  logic               rsp_valid;
  logic               rsp_success;
  logic               rsp_full;
  logic [CMP_W-1:0]   rsp_cmp;
  logic [ENTRY_W-1:0] rsp_count;

  assign mid      = lo + ((hi - lo) >> 1);
  assign probe_lt = lt_flags[mid[IW-1:0]];
  assign probe_eq = eq_flags[mid[IW-1:0]];
  assign fire     = (state == FINISH) && (!rsp_valid || rsp.ready);

  always_comb begin
    count_next = count;
    if (ok && act == ACT_INSERT) begin
      count_next = count + CW'(1);
    end else if (ok && act == ACT_DELETE) begin
      count_next = count - CW'(1);
    end
  end

  assign cmd.load_flags = (state == COMPARE);
  assign cmd.do_insert  = fire && ok && (act == ACT_INSERT);
  assign cmd.do_delete  = fire && ok && (act == ACT_DELETE);

  assign req.ready       = (state == IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.success     = rsp_success;
  assign rsp.table_full  = rsp_full;
  assign rsp.comparisons = rsp_cmp;
  assign rsp.entry_count = rsp_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req.valid) begin
            act    <= req.action;
            key    <= req.key;
            ok     <= 1'b0;
            full   <= 1'b0;
            probes <= '0;
            lo     <= '0;
            hi     <= count;
            if (req.action == ACT_INSERT && count == FULL_COUNT) begin
              full  <= 1'b1;
              state <= FINISH;
            end else if (req.action inside {ACT_INSERT, ACT_SEARCH, ACT_DELETE}) begin
              state <= COMPARE;
            end else begin
              state <= FINISH;
            end
          end
        end
        COMPARE: begin
          state <= PROBE;
        end
        PROBE: begin
          if (lo < hi) begin
            probes <= probes + CMP_W'(1);
            if (act != ACT_INSERT && probe_eq) begin
              ok    <= 1'b1;
              pos   <= mid[IW-1:0];
              state <= FINISH;
            end else if (probe_lt) begin
              lo <= mid + CW'(1);
            end else begin
              hi <= mid;
            end
          end else begin
            if (act == ACT_INSERT) begin
              ok  <= 1'b1;
              pos <= lo[IW-1:0];
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          if (fire) begin
            count <= count_next;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (fire) begin
        rsp_valid   <= 1'b1;
        rsp_success <= ok;
        rsp_full    <= full;
        rsp_cmp     <= probes;
        rsp_count   <= ENTRY_W'(count_next);
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `STBS_ASSERT_NOW(a_probe_in_range, clk, rst, (state == PROBE) && (lo < hi), mid < count, "probe index beyond the filled part of the table")
  `STBS_ASSERT_NOW(a_range_order, clk, rst, state == PROBE, lo <= hi, "search bounds crossed")
  `STBS_ASSERT_NOW(a_full_refusal, clk, rst, fire && full, (act == ACT_INSERT) && (count == FULL_COUNT) && !ok, "refusal without a full table")
  `STBS_ASSERT_NEXT(a_insert_grows, clk, rst, cmd.do_insert, (count - $past(count)) == CW'(1), "insert did not grow the entry count by one")

endmodule

/* design/sorted_table_binary_search_core.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search core
// Ascending table of signed keys with insert, search and delete requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (action, key) and each one gives
// exactly one item on the rsp channel (success, table_full, comparisons,
// entry_count). A request is taken only while the sequencer is idle.
// After acceptance, every cell compares its key with the request key and
// registers its flags, then the sequencer makes one binary-search probe
// per cycle on the registered cell flags, stopping early when a search or
// delete hits its key. The FINISH state then shifts the cell row for an
// insert or delete and writes the result once the output register is
// free. A refused insert or an unused action code skips the compare and
// probe states and goes straight to FINISH. The next request may be
// accepted once the result is written and the sequencer is back in IDLE.
// Reset clears the entry count and the response register; no clearing
// pass is needed. While the receiver stalls, one result waits in the
// output register and the core still accepts and processes the next
// request, holding its own result until the register frees.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core import stbs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  stbs_req_if.sink   req,
  stbs_rsp_if.source rsp
);

  localparam int IW = $clog2(DEPTH);

  stbs_cmd_t               cmd;
  logic [IW-1:0]           pos;
  logic signed [KEY_W-1:0] key;
  logic [DEPTH-1:0]        lt_flags;
  logic [DEPTH-1:0]        eq_flags;

  stbs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .lt_flags (lt_flags),
    .eq_flags (eq_flags),
    .cmd      (cmd),
    .pos      (pos),
    .key      (key)
  );

  stbs_cell_row #(.DEPTH(DEPTH)) u_row (
    .clk      (clk),
    .cmd      (cmd),
    .pos      (pos),
    .key_in   (key),
    .lt_flags (lt_flags),
    .eq_flags (eq_flags)
  );

endmodule

/* verif/sorted_table_binary_search_core_tb.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search core testbench
// Sends insert, search and delete requests and checks every response item
// against a software copy of the sorted table. Covers extreme keys, duplicates,
// empty and full tables, unused action codes, idle and stall mixes, and a long
// response stall that backs requests up.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core_tb;
  import stbs_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 40;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic               success;
    logic               table_full;
    logic [CMP_W-1:0]   comparisons;
    logic [ENTRY_W-1:0] entry_count;
  } table_result_t;

  logic clk;
  logic rst;

  stbs_req_if req_if ();
  stbs_rsp_if rsp_if ();

  sorted_table_binary_search_core #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  logic signed [KEY_W-1:0] table_keys [DEPTH];
  int                      stored_count;
  table_result_t           pending_results [$];
  int                      error_count;
  int                      src_idle_pct;
  int                      rsp_stall_pct;
  int                      rsp_hold_left;
  int                      cycles_run;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Binary search over the kept keys, applied to the software table.
  function automatic table_result_t apply_request(input logic [ACT_W-1:0] act,
                                                  input logic signed [KEY_W-1:0] k);
    table_result_t r;
    int lo;
    int hi;
    int mid;
    int probes;
    int i;
    r = '0;
    lo = 0;
    hi = stored_count;
    probes = 0;
    if (act == ACT_INSERT) begin
      if (stored_count >= DEPTH) begin
        r.table_full = 1'b1;
      end else begin
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          probes++;
          if (table_keys[mid] < k) lo = mid + 1;
          else hi = mid;
        end
        for (i = stored_count; i > lo; i--) table_keys[i] = table_keys[i-1];
        table_keys[lo] = k;
        stored_count++;
        r.success = 1'b1;
      end
    end else if (act == ACT_SEARCH || act == ACT_DELETE) begin
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        probes++;
        if (table_keys[mid] == k) begin
          r.success = 1'b1;
          if (act == ACT_DELETE) begin
            for (i = mid; i < stored_count - 1; i++) table_keys[i] = table_keys[i+1];
            stored_count--;
          end
          break;
        end
        if (table_keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
    end
    r.comparisons = probes[CMP_W-1:0];
    r.entry_count = stored_count[ENTRY_W-1:0];
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 35 && stored_count > 0) begin
      k = table_keys[$urandom_range(stored_count - 1)];
    end else if (sel < 60) begin
      k = $urandom_range(16);
      k = k - 8;
    end else if (sel < 70) begin
      case ($urandom_range(3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = '0;
        default: k = -1;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items keep the channel busy.
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [KEY_W-1:0] k);
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.key    <= k;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(apply_request(act, k));
    @(negedge clk);
  endtask

  task automatic set_traffic(input int src_pct, input int stall_pct, input int hold);
    req_if.valid <= 1'b0;
    @(posedge clk);
    src_idle_pct  = src_pct;
    rsp_stall_pct = stall_pct;
    rsp_hold_left = hold;
    @(negedge clk);
  endtask

  task automatic test_directed_cases();
    set_traffic(0, 0, 0);
    send_request(ACT_SEARCH, '0);
    send_request(ACT_DELETE, 5);
    send_request(ACT_UNUSED, -1);
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_INSERT, KEY_MIN);
    send_request(ACT_INSERT, '0);
    send_request(ACT_INSERT, '0);
    send_request(ACT_INSERT, -1);
    send_request(ACT_SEARCH, KEY_MIN);
    send_request(ACT_SEARCH, KEY_MAX);
    send_request(ACT_SEARCH, 12345);
    send_request(ACT_DELETE, '0);
    send_request(ACT_DELETE, '0);
    send_request(ACT_DELETE, '0);
    send_request(ACT_UNUSED, KEY_MAX);
    send_request(ACT_INSERT, -5);
    send_request(ACT_DELETE, KEY_MIN);
    send_request(ACT_DELETE, KEY_MAX);
    send_request(ACT_DELETE, -1);
    send_request(ACT_DELETE, -5);
    send_request(ACT_SEARCH, -5);
  endtask

  task automatic test_random_mix(input int src_pct, input int stall_pct, input int n_items);
    int sel;
    int insert_pct;
    set_traffic(src_pct, stall_pct, 0);
    repeat (n_items) begin
      sel = $urandom_range(99);
      insert_pct = (stored_count < 48) ? 58 : 36;
      if (sel < 3) send_request(ACT_UNUSED, $urandom);
      else if (sel < 3 + insert_pct) send_request(ACT_INSERT, pick_key());
      else if (sel % 2 == 0) send_request(ACT_SEARCH, pick_key());
      else send_request(ACT_DELETE, pick_key());
    end
  endtask

  task automatic test_output_backpressure();
    set_traffic(0, 0, 300);
    repeat (10) send_request(ACT_W'($urandom_range(2)), pick_key());
  endtask

  task automatic test_full_table();
    set_traffic(0, 0, 0);
    while (stored_count < DEPTH) send_request(ACT_INSERT, pick_key());
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_INSERT, KEY_MIN);
    send_request(ACT_UNUSED, '0);
    repeat (6) send_request(ACT_SEARCH, pick_key());
    repeat (6) send_request(ACT_DELETE, pick_key());
    send_request(ACT_INSERT, pick_key());
    send_request(ACT_INSERT, pick_key());
  endtask

  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_hold_left = rsp_hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t unexpected response item: success %0d table_full %0d comparisons %0d entry_count %0d",
                   $time, rsp_if.success, rsp_if.table_full, rsp_if.comparisons,
                   rsp_if.entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_if.success !== exp_r.success) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t success mismatch: expected %0d actual %0d",
                     $time, exp_r.success, rsp_if.success);
        end
        if (rsp_if.table_full !== exp_r.table_full) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t table_full mismatch: expected %0d actual %0d",
                     $time, exp_r.table_full, rsp_if.table_full);
        end
        if (rsp_if.comparisons !== exp_r.comparisons) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t comparisons mismatch: expected %0d actual %0d",
                     $time, exp_r.comparisons, rsp_if.comparisons);
        end
        if (rsp_if.entry_count !== exp_r.entry_count) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t entry_count mismatch: expected %0d actual %0d",
                     $time, exp_r.entry_count, rsp_if.entry_count);
        end
      end
    end
  end

  initial begin
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    req_if.valid  = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.key    = '0;
    rsp_if.ready  = 1'b0;
    src_idle_pct  = 0;
    rsp_stall_pct = 0;
    rsp_hold_left = 0;
    stored_count  = 0;
    error_count   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_mix(0, 0, 140);
    test_random_mix(76, 0, 140);
    test_random_mix(0, 76, 140);
    test_random_mix(11, 11, 140);
    test_output_backpressure();
    test_full_table();

    set_traffic(0, 0, 0);
    while (pending_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/stbs_pkg.sv
design/stbs_req_if.sv
design/stbs_rsp_if.sv
design/stbs_cell.sv
design/stbs_cell_row.sv
design/stbs_ctrl.sv
design/sorted_table_binary_search_core.sv
verif/sorted_table_binary_search_core_tb.sv
